// ----- hw/rtl/ols_pkg.sv -----
// ============================================================================
// ols_pkg: shared types and constants of the ordered list store
// Request and result field widths, stream word layouts, operation codes and
// status codes used by the store and by its interface checker.
// ============================================================================
package ols_pkg;

    // Request fields, packed from the lowest bit up: func, position, value.
    localparam int FUNC_BITS      = 3;
    localparam int POS_BITS       = 4;
    localparam int VALUE_BITS     = 32;
    localparam int IN_FUNC_LSB    = 0;
    localparam int IN_POS_LSB     = IN_FUNC_LSB + FUNC_BITS;
    localparam int IN_VALUE_LSB   = IN_POS_LSB + POS_BITS;
    localparam int IN_USED_BITS   = IN_VALUE_LSB + VALUE_BITS;
    localparam int IN_TDATA_BITS  = ((IN_USED_BITS + 7) / 8) * 8;

    // Result fields, packed from the lowest bit up: read_value, entry_count,
    // status.
    localparam int READ_BITS      = 32;
    localparam int COUNT_BITS     = 5;
    localparam int STATUS_BITS    = 2;
    localparam int OUT_READ_LSB   = 0;
    localparam int OUT_COUNT_LSB  = OUT_READ_LSB + READ_BITS;
    localparam int OUT_STATUS_LSB = OUT_COUNT_LSB + COUNT_BITS;
    localparam int OUT_USED_BITS  = OUT_STATUS_LSB + STATUS_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

    typedef enum logic [FUNC_BITS-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_APPEND     = 3'd1,
        FN_REMOVE     = 3'd2,
        FN_SET        = 3'd3,
        FN_GET        = 3'd4
    } t_func;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_ZERO  = 2'd3
    } t_status;

endpackage

// ----- hw/rtl/ordered_list_store.sv -----
// ============================================================================
// ordered_list_store: fixed-capacity ordered list of words
// Push front, append, remove at index, set and get on a list held in one
// synchronous single-port-write, single-port-read memory.
// ============================================================================
// Usage
// Requests arrive on the s_axis channel, one item per operation; every item
// produces exactly one result item on the m_axis channel carrying the word
// read by a get, the number of entries held afterwards and a status code.
// The block works on one request at a time. A request is taken only while
// the sequencer is idle. Set and append pass through S_PUT and S_FIN, get
// through S_LOOK, S_CHECK and S_FIN, and unknown operations and refused
// requests go straight to S_FIN. Push front moves every entry up and remove
// moves the entries after the position down, through the memory one per
// cycle (read one cycle, written back the next). The finished result sits
// in an output register; a new request is accepted while that result still
// waits for the receiver. If the receiver stalls, the next result waits in
// the sequencer until the register frees. Reset clears the count, the
// state, the pending write and the output valid; the memory itself is never
// cleared because entries at or above the count are never read, so the list
// is usable as soon as reset is released.
// ============================================================================
module ordered_list_store
    import ols_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Request stream.
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // tdata: func [2:0], position [6:3], value [38:7], zero pad [39].
    input  logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata,
    // Result stream.
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // tdata: read_value [31:0], entry_count [36:32], status [38:37],
    // zero pad [39].
    output logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata
);

    // Address width of the memory and width of the count, which must be able
    // to hold DEPTH itself. PW is wide enough to compare a position with it.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_BITS) ? CW : POS_BITS;

    typedef enum logic [2:0] {
        S_IDLE,      // waiting for a request
        S_LOOK,      // read the addressed entry
        S_CHECK,     // examine the entry for get or remove
        S_SHIFT_UP,  // push front: move entries up, highest first
        S_SHIFT_DN,  // remove: move later entries down, lowest first
        S_DRAIN,     // last moved word is written back
        S_PUT,       // write the request word
        S_FIN        // hand the result to the output register
    } t_state;

    // The entry storage; a location is only read below the count.
    logic [WORD_BITS-1:0] r_mem [DEPTH];

    t_state               r_state;
    t_func                r_func;
    t_status              r_status;
    logic [WORD_BITS-1:0] r_val;
    logic [WORD_BITS-1:0] r_read;
    logic [WORD_BITS-1:0] r_rd_data;
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_idx;
    logic [AW-1:0]        r_wr_addr;
    logic                 r_wr_pend;
    logic                 r_out_valid;
    logic [OUT_TDATA_BITS-1:0] r_out_data;

    logic                 in_accept;
    t_func                in_func;
    logic [POS_BITS-1:0]  in_pos;
    logic [VALUE_BITS-1:0] in_value;
    logic                 list_full;
    logic                 pos_ok;
    logic                 idx_is_last;
    logic                 out_free;

    logic                 mem_rd_en;
    logic [AW-1:0]        mem_rd_addr;
    logic                 mem_wr_en;
    logic [AW-1:0]        mem_wr_addr;
    logic [WORD_BITS-1:0] mem_wr_data;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign in_func         = t_func'(i_s_axis_tdata[IN_POS_LSB-1:IN_FUNC_LSB]);
    assign in_pos          = i_s_axis_tdata[IN_VALUE_LSB-1:IN_POS_LSB];
    assign in_value        = i_s_axis_tdata[IN_USED_BITS-1:IN_VALUE_LSB];

    assign list_full   = (r_count == CW'(DEPTH));
    assign pos_ok      = (PW'(in_pos) < PW'(r_count));
    assign idx_is_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign out_free    = !r_out_valid || i_m_axis_tready;

    // Memory port control. A moved word is written in the cycle after its read;
    // the request word is written in S_PUT, which never overlaps a pending
    // move. Shifts read and write addresses two apart, so no forwarding is
    // needed.
    always_comb begin
        mem_rd_en   = (r_state == S_LOOK) || (r_state == S_SHIFT_UP) ||
                      (r_state == S_SHIFT_DN);
        mem_rd_addr = r_idx;
        mem_wr_en   = r_wr_pend || (r_state == S_PUT);
        mem_wr_addr = (r_state == S_PUT) ? r_idx : r_wr_addr;
        mem_wr_data = (r_state == S_PUT) ? r_val : r_rd_data;
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rd_data <= r_mem[mem_rd_addr];
        end
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result takes the register in the cycle the old one leaves.
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_func   <= in_func;
                        r_val    <= WORD_BITS'(in_value);
                        r_read   <= '0;
                        unique case (in_func)
                            FN_PUSH_FRONT: begin
                                if (list_full) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_FIN;
                                end else if (r_count == '0) begin
                                    r_status <= ST_OK;
                                    r_idx    <= '0;
                                    r_state  <= S_PUT;
                                end else begin
                                    r_status <= ST_OK;
                                    r_idx    <= AW'(r_count - CW'(1));
                                    r_state  <= S_SHIFT_UP;
                                end
                            end
                            FN_APPEND: begin
                                if (list_full) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_status <= ST_OK;
                                    r_idx    <= AW'(r_count);
                                    r_state  <= S_PUT;
                                end
                            end
                            FN_REMOVE, FN_GET: begin
                                if (!pos_ok) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_status <= ST_OK;
                                    r_idx    <= AW'(in_pos);
                                    r_state  <= S_LOOK;
                                end
                            end
                            FN_SET: begin
                                if (!pos_ok) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_status <= ST_OK;
                                    r_idx    <= AW'(in_pos);
                                    r_state  <= S_PUT;
                                end
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_state  <= S_FIN;
                            end
                        endcase
                    end
                end
                S_LOOK: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_func == FN_GET) begin
                        r_read  <= r_rd_data;
                        r_state <= S_FIN;
                    end else if (r_rd_data == '0) begin
                        r_status <= ST_ZERO;
                        r_state  <= S_FIN;
                    end else if (idx_is_last) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_FIN;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_SHIFT_DN;
                    end
                end
                S_SHIFT_UP: begin
                    r_wr_pend <= 1'b1;
                    r_wr_addr <= r_idx + AW'(1);
                    if (r_idx == '0) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx - AW'(1);
                    end
                end
                S_SHIFT_DN: begin
                    r_wr_pend <= 1'b1;
                    r_wr_addr <= r_idx - AW'(1);
                    if (idx_is_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_DRAIN: begin
                    r_wr_pend <= 1'b0;
                    if (r_func == FN_PUSH_FRONT) begin
                        r_state <= S_PUT;
                    end else begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_FIN;
                    end
                end
                S_PUT: begin
                    if (r_func == FN_PUSH_FRONT || r_func == FN_APPEND) begin
                        r_count <= r_count + CW'(1);
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_data  <= OUT_TDATA_BITS'({r_status,
                                                         COUNT_BITS'(r_count),
                                                         READ_BITS'(r_read)});
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ----- hw/rtl/ols_checker.sv -----
// ============================================================================
// ols_checker: port-level checks of the ordered list store
// Watches the request and result channels and flags results or handshake
// behavior the store can never produce.
// ============================================================================
module ols_checker
    import ols_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_axis_tvalid,
    input logic                      i_s_axis_tready,
    input logic                      i_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [OUT_TDATA_BITS-1:0] i_m_axis_tdata
);

    logic [READ_BITS-1:0]   read_value;
    logic [COUNT_BITS-1:0]  entry_count;
    logic [STATUS_BITS-1:0] status;

    assign read_value  = i_m_axis_tdata[OUT_COUNT_LSB-1:OUT_READ_LSB];
    assign entry_count = i_m_axis_tdata[OUT_STATUS_LSB-1:OUT_COUNT_LSB];
    assign status      = i_m_axis_tdata[OUT_USED_BITS-1:OUT_STATUS_LSB];

    // One request at a time: the request side closes after every item.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && i_s_axis_tready) |=> !i_s_axis_tready)
        else $error("request taken while the previous one is in progress");

    // An error never carries read data.
    a_error_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_axis_tvalid && status != ST_OK) |-> (read_value == '0))
        else $error("result with an error status carries read data");

    // The reported count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> (32'(entry_count) <= 32'(DEPTH)))
        else $error("entry count above capacity");

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_axis_tvalid && !i_m_axis_tready) |=> i_m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its data.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_axis_tvalid && !i_m_axis_tready) |=> $stable(i_m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind ordered_list_store ols_checker #(
    .DEPTH(DEPTH)
) u_ols_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);

// ----- tb/ordered_list_store_tb.sv -----
// ============================================================================
// ordered_list_store_tb: self-checking bench for the ordered list store
// Drives push front, append, remove, set, get and unused operation codes
// into the request stream and keeps its own copy of the list. Each result
// item is checked field by field against the oldest prediction. Both stream
// sides stall at random, with some stretches at full rate.
// ============================================================================
`timescale 1ns / 1ps

module ordered_list_store_tb;
    import ols_pkg::*;

    // The list capacity and word width that the block is built with.
    localparam int LIST_DEPTH      = 16;
    localparam int LIST_WORD_BITS  = 32;

    // Operation codes that the block does not decode; it must answer them
    // with an ok status and leave the list alone.
    localparam logic [FUNC_BITS-1:0] FN_RESERVED_LO = 3'd5;
    localparam logic [FUNC_BITS-1:0] FN_RESERVED_HI = 3'd7;

    // Random traffic is sent in MIX_PHASES phases of ITEMS_PER_PHASE items each.
    localparam int MIX_PHASES      = 11;
    localparam int ITEMS_PER_PHASE = 50;

    // Worst case per item is roughly a full sender gap, a shift across the
    // whole list and a full receiver stall. About 680 items at that worst
    // case still leave the limit plenty of margin.
    localparam int CYCLE_LIMIT     = 250000;

    // Bias of the random traffic: toward filling, toward draining, or even.
    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix_bias;

    typedef struct packed {
        logic [READ_BITS-1:0]  read_value;
        logic [COUNT_BITS-1:0] entry_count;
        t_status               status;
    } t_list_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    // tdata: func [2:0], position [6:3], value [38:7], zero pad [39].
    logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    // tdata: read_value [31:0], entry_count [36:32], status [38:37],
    // zero pad [39].
    logic [OUT_TDATA_BITS-1:0] m_tdata;

    // Shadow copy of the list that the predictor works on.
    logic [LIST_WORD_BITS-1:0] shadow_words [LIST_DEPTH];
    int                        shadow_len;

    // Predicted results, oldest first.
    t_list_result              pending_results [$];

    int                        send_gap_max = 7;
    int                        recv_stall_max = 7;
    int                        recv_stall_left = 0;
    int                        error_count = 0;
    int                        requests_sent = 0;
    int                        results_checked = 0;
    int                        reserved_sent = 0;
    int                        status_hits [4] = '{0, 0, 0, 0};
    int                        cycle_count = 0;

    ordered_list_store #(
        .DEPTH     (LIST_DEPTH),
        .WORD_BITS (LIST_WORD_BITS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still expected.",
                     cycle_count, pending_results.size());
            $display("ordered_list_store test failed");
            $finish;
        end
    end

    // Applies one request to the shadow list and returns the result that the
    // block must give for it. Checks follow the block's order: capacity first
    // for the two insert operations, then range, then the zero-entry rule of
    // remove.
    function automatic t_list_result predict_list_op(
        input logic [FUNC_BITS-1:0]  func,
        input logic [POS_BITS-1:0]   pos,
        input logic [VALUE_BITS-1:0] value
    );
        t_list_result res;
        int           idx;
        res.read_value = '0;
        res.status     = ST_OK;
        idx            = int'(pos);
        case (func)
            FN_PUSH_FRONT: begin
                if (shadow_len >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = shadow_len; i > 0; i--) begin
                        shadow_words[i] = shadow_words[i - 1];
                    end
                    shadow_words[0] = value[LIST_WORD_BITS-1:0];
                    shadow_len++;
                end
            end
            FN_APPEND: begin
                if (shadow_len >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_words[shadow_len] = value[LIST_WORD_BITS-1:0];
                    shadow_len++;
                end
            end
            FN_REMOVE: begin
                if (idx >= shadow_len) begin
                    res.status = ST_RANGE;
                end else if (shadow_words[idx] == '0) begin
                    res.status = ST_ZERO;
                end else begin
                    for (int i = idx; i + 1 < shadow_len; i++) begin
                        shadow_words[i] = shadow_words[i + 1];
                    end
                    shadow_words[shadow_len - 1] = '0;
                    shadow_len--;
                end
            end
            FN_SET: begin
                if (idx >= shadow_len) begin
                    res.status = ST_RANGE;
                end else begin
                    shadow_words[idx] = value[LIST_WORD_BITS-1:0];
                end
            end
            FN_GET: begin
                if (idx >= shadow_len) begin
                    res.status = ST_RANGE;
                end else begin
                    res.read_value = READ_BITS'(shadow_words[idx]);
                end
            end
            default: begin
                // Unused codes change nothing and report ok.
            end
        endcase
        res.entry_count = COUNT_BITS'(shadow_len);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 40) begin
            $display("MISMATCH at result %0d: %s", results_checked, what);
        end
    endtask

    // Sends one request. The sender first idles for a random gap, then
    // holds the item until the block takes it. The prediction is
    // made at the accepting edge so that the shadow list always matches what
    // the block has been given.
    task automatic send_request(
        input logic [FUNC_BITS-1:0]  func,
        input logic [POS_BITS-1:0]   pos,
        input logic [VALUE_BITS-1:0] value
    );
        logic [IN_TDATA_BITS-1:0] word;
        int                       gap;
        gap  = $urandom_range(0, send_gap_max);
        word = '0;
        word[IN_FUNC_LSB +: FUNC_BITS]   = func;
        word[IN_POS_LSB +: POS_BITS]     = pos;
        word[IN_VALUE_LSB +: VALUE_BITS] = value;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        pending_results.push_back(predict_list_op(func, pos, value));
        requests_sent++;
        if (func >= FN_RESERVED_LO) begin
            reserved_sent++;
        end
    endtask

    // Drops the request valid and waits until every predicted result has
    // come back. The valid is lowered in the step of the last acceptance, so
    // the block never sees the same item twice.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Result side: sample at each rising edge, check an accepted item against
    // the oldest prediction, then draw how long to stall before the next one.
    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        if (!i_rst_n) begin
            m_tready        <= 1'b0;
            recv_stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.read_value  = m_tdata[OUT_READ_LSB +: READ_BITS];
                got.entry_count = m_tdata[OUT_COUNT_LSB +: COUNT_BITS];
                got.status      = t_status'(m_tdata[OUT_STATUS_LSB +: STATUS_BITS]);
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result item with nothing outstanding, data %h",
                                              m_tdata));
                end else begin
                    want = pending_results.pop_front();
                    if (got.read_value !== want.read_value) begin
                        report_mismatch($sformatf("read_value %h, expected %h",
                                                  got.read_value, want.read_value));
                    end
                    if (got.entry_count !== want.entry_count) begin
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  got.entry_count, want.entry_count));
                    end
                    if (got.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    end
                    status_hits[want.status]++;
                end
                results_checked++;
                recv_stall_left = $urandom_range(0, recv_stall_max);
            end
            if (recv_stall_left > 0) begin
                recv_stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Hand-picked requests on a list that starts empty: every operation on
    // the empty list, the unused codes, the extremes of position and value,
    // reads at both ends of the list, and a remove that hits a zero entry.
    task automatic test_directed_ops();
        send_request(FN_GET, 4'd0, '0);
        send_request(FN_REMOVE, 4'd15, '0);
        send_request(FN_SET, 4'd0, 32'hFFFF_FFFF);
        for (int f = FN_RESERVED_LO; f <= FN_RESERVED_HI; f++) begin
            send_request(FUNC_BITS'(f), 4'd15, 32'hFFFF_FFFF);
        end
        send_request(FN_PUSH_FRONT, 4'd15, 32'hFFFF_FFFF);
        send_request(FN_APPEND, 4'd0, 32'h0000_0000);
        send_request(FN_PUSH_FRONT, 4'd0, 32'h0000_0001);
        // The list is now 1, all ones, 0; the last entry holds zero.
        send_request(FN_REMOVE, 4'd2, '0);
        send_request(FN_GET, 4'd0, '0);
        send_request(FN_GET, 4'd1, '0);
        send_request(FN_GET, 4'd2, '0);
        send_request(FN_GET, 4'd3, '0);
        send_request(FN_SET, 4'd2, 32'hA5A5_5A5A);
        send_request(FN_REMOVE, 4'd2, '0);
        send_request(FN_REMOVE, 4'd0, '0);
        // One entry left: an index equal to the count is already out of range.
        send_request(FN_SET, 4'd1, 32'h1234_5678);
        send_request(FN_REMOVE, 4'd0, '0);
        send_request(FN_APPEND, 4'd0, '0);
        send_request(FN_REMOVE, 4'd0, '0);
        send_request(FN_SET, 4'd0, 32'h8000_0000);
        send_request(FN_REMOVE, 4'd0, '0);
    endtask

    // Fills the list to capacity, then probes the full list: both inserts
    // must be refused, the last slot must be readable and writable, and a
    // push front must shift the whole list once a slot frees up.
    task automatic test_full_list();
        while (shadow_len < LIST_DEPTH) begin
            send_request(FN_APPEND, POS_BITS'($urandom), $urandom | 32'h1);
        end
        send_request(FN_PUSH_FRONT, 4'd0, 32'hDEAD_BEEF);
        send_request(FN_APPEND, 4'd15, 32'hFFFF_FFFF);
        send_request(FN_GET, 4'd15, '0);
        send_request(FN_GET, 4'd0, '0);
        send_request(FN_SET, 4'd15, '0);
        send_request(FN_REMOVE, 4'd15, '0);
        send_request(FN_REMOVE, 4'd14, '0);
        send_request(FN_PUSH_FRONT, 4'd0, 32'hFFFF_FFFF);
        send_request(FN_GET, 4'd15, '0);
        send_request(FN_GET, 4'd0, '0);
        send_request(FN_APPEND, 4'd0, 32'h0000_0001);
    endtask

    // Removes entries at random places until the list is empty. A zero entry
    // is first overwritten so that the remove goes through.
    task automatic test_drain_to_empty();
        logic [POS_BITS-1:0] pos;
        while (shadow_len > 0) begin
            pos = POS_BITS'($urandom_range(0, shadow_len - 1));
            if (shadow_words[pos] == '0) begin
                send_request(FN_SET, pos, $urandom | 32'h1);
            end
            send_request(FN_REMOVE, pos, $urandom);
        end
        send_request(FN_GET, 4'd0, '0);
        send_request(FN_REMOVE, 4'd0, '0);
    endtask

    // Random traffic in phases. Each phase leans toward filling, draining or
    // neither, so the count sweeps across its whole range many times. Most
    // positions fall inside the list; values are often zero or all ones so
    // that the zero-entry rule of remove comes up regularly.
    task automatic test_random_mix();
        t_mix_bias               bias;
        int                      op_roll;
        int                      val_roll;
        logic [FUNC_BITS-1:0]    func;
        logic [POS_BITS-1:0]     pos;
        logic [VALUE_BITS-1:0]   value;
        for (int phase = 0; phase < MIX_PHASES; phase++) begin
            bias = t_mix_bias'(phase % 3);
            // Every fourth phase runs both sides at full rate.
            if (phase % 4 == 1) begin
                send_gap_max   = 0;
                recv_stall_max = 0;
            end else begin
                send_gap_max   = 7;
                recv_stall_max = 7;
            end
            // Midway, let the block run dry before sending more.
            if (phase == MIX_PHASES / 2) begin
                wait_results_drained();
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                op_roll  = $urandom_range(0, 99);
                val_roll = $urandom_range(0, 99);
                if (val_roll < 12) begin
                    value = '0;
                end else if (val_roll < 17) begin
                    value = '1;
                end else begin
                    value = $urandom;
                end
                if (shadow_len != 0 && $urandom_range(0, 99) < 85) begin
                    pos = POS_BITS'($urandom_range(0, shadow_len - 1));
                end else begin
                    pos = POS_BITS'($urandom_range(0, LIST_DEPTH - 1));
                end
                if (op_roll < 5) begin
                    func = FUNC_BITS'($urandom_range(FN_RESERVED_LO, FN_RESERVED_HI));
                end else begin
                    op_roll = $urandom_range(0, 99);
                    case (bias)
                        MIX_FILL: begin
                            func = (op_roll < 30) ? FN_PUSH_FRONT :
                                   (op_roll < 60) ? FN_APPEND :
                                   (op_roll < 70) ? FN_REMOVE :
                                   (op_roll < 82) ? FN_SET : FN_GET;
                        end
                        MIX_DRAIN: begin
                            func = (op_roll < 8)  ? FN_PUSH_FRONT :
                                   (op_roll < 16) ? FN_APPEND :
                                   (op_roll < 60) ? FN_REMOVE :
                                   (op_roll < 75) ? FN_SET : FN_GET;
                        end
                        default: begin
                            func = (op_roll < 20) ? FN_PUSH_FRONT :
                                   (op_roll < 40) ? FN_APPEND :
                                   (op_roll < 60) ? FN_REMOVE :
                                   (op_roll < 78) ? FN_SET : FN_GET;
                        end
                    endcase
                end
                send_request(func, pos, value);
            end
        end
        send_gap_max   = 7;
        recv_stall_max = 7;
    endtask

    initial begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            shadow_words[i] = '0;
        end
        shadow_len = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_ops();
        wait_results_drained();
        test_full_list();
        test_drain_to_empty();
        wait_results_drained();
        test_random_mix();
        test_full_list();
        test_drain_to_empty();

        // Let the last results come back, then give the block time to show
        // any stray result item it should not produce.
        wait_results_drained();
        repeat (LIST_DEPTH + 8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived",
                                      pending_results.size()));
        end

        $display("Run covered %0d requests (%0d with unused codes), %0d results checked.",
                 requests_sent, reserved_sent, results_checked);
        $display("Statuses seen: ok %0d, list full %0d, out of range %0d, zero skipped %0d.",
                 status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_RANGE],
                 status_hits[ST_ZERO]);
        if (error_count == 0) begin
            $display("ordered_list_store test passed");
        end else begin
            $display("ordered_list_store test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ols_pkg.sv
hw/rtl/ordered_list_store.sv
hw/rtl/ols_checker.sv
tb/ordered_list_store_tb.sv
